// File: design/compressed_rtf_lz_decoder_macros.svh
// ---------------------------------------------------------------------------
// Compressed RTF decoder assertion macros
// Shared assertion forms for the decoder, clocked on clock, off in reset.
// ---------------------------------------------------------------------------
`ifndef COMPRESSED_RTF_LZ_DECODER_MACROS_SVH
`define COMPRESSED_RTF_LZ_DECODER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CRTF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CRTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/crtf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compressed RTF decoder package
// Format constants, the preset dictionary text and the CRC step.
// ---------------------------------------------------------------------------
package crtf_pkg;

   localparam int unsigned RingAw = 12;
   localparam int unsigned RingDepth = 1 << RingAw;
   localparam int unsigned PrefixLen = 207;
   localparam int unsigned HeaderBytes = 16;

   localparam logic [31:0] TypeCompressed = 32'h75465a4c;
   localparam logic [31:0] TypeUncompressed = 32'h414c454d;
   localparam logic [31:0] CrcPoly = 32'hedb88320;

   localparam logic [PrefixLen*8-1:0] RtfPrefix = {
      "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
      "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript ",
      "\\fdecor MS San",
      "s SerifSymbolArialTimes New RomanCourier",
      "{\\colortbl\\red0\\green0\\blue0\015\n\\par \\pard\\plain\\",
      "f0\\fs20\\b\\i\\u\\tab\\tx"
   };

   function automatic logic [7:0] prefix_byte(input logic [RingAw-1:0] addr);
      logic [7:0] v;
      v = 8'h00;
      if (addr < RingAw'(PrefixLen)) begin
         v = RtfPrefix[(PrefixLen - 1 - int'(addr)) * 8 +: 8];
      end
      return v;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: design/crtf_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel
// Carries one stored stream byte per request.
// ---------------------------------------------------------------------------
interface crtf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       last_byte;

   modport source (output valid, output stream_byte, output last_byte, input ready);
   modport sink (input valid, input stream_byte, input last_byte, output ready);
endinterface

// File: design/crtf_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result channel
// Carries one decoded byte or one end-of-stream status per result.
// ---------------------------------------------------------------------------
interface crtf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       status_valid;
   logic [2:0] status;
   logic       last_result;

   modport source (output valid, output out_byte, output out_valid, output status_valid,
                   output status, output last_result, input ready);
   modport sink (input valid, input out_byte, input out_valid, input status_valid,
                 input status, input last_result, output ready);
endinterface

// File: design/crtf_ring.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// History ring
// 4096-byte history memory with write pointer and fill count; entries not
// yet written in the current stream read as the preset dictionary.
// ---------------------------------------------------------------------------
module crtf_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           wr_en,
   input  logic [7:0]                     wr_data,
   input  logic                           rd_en,
   input  logic [crtf_pkg::RingAw-1:0]    rd_addr,
   output logic [7:0]                     rd_data,
   output logic [crtf_pkg::RingAw-1:0]    wr_pos
);

   logic [7:0]                  mem [crtf_pkg::RingDepth];
   logic [crtf_pkg::RingAw-1:0] wp_ff, wp_in;
   logic [crtf_pkg::RingAw:0]   fill_ff, fill_in;
   logic [7:0]                  mem_q_ff;
   logic [7:0]                  pre_ff;
   logic                        fresh_ff;
   logic [crtf_pkg::RingAw-1:0] age;

   assign age = rd_addr - crtf_pkg::RingAw'(crtf_pkg::PrefixLen);

   always_comb begin
      wp_in = wp_ff;
      fill_in = fill_ff;
      if (clear) begin
         wp_in = crtf_pkg::RingAw'(crtf_pkg::PrefixLen);
         fill_in = '0;
      end else if (wr_en) begin
         wp_in = wp_ff + 1'b1;
         if (!fill_ff[crtf_pkg::RingAw]) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= crtf_pkg::RingAw'(crtf_pkg::PrefixLen);
         fill_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         pre_ff <= crtf_pkg::prefix_byte(rd_addr);
         fresh_ff <= ({1'b0, age} < fill_ff);
      end
   end

   assign rd_data = fresh_ff ? mem_q_ff : pre_ff;
   assign wr_pos = wp_ff;

endmodule

// File: design/compressed_rtf_lz_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compressed RTF decoder
// Streaming decoder for compressed RTF: header parse, LZ expansion through
// a history ring, CRC-32 check and an end-of-stream status.
// ---------------------------------------------------------------------------
// The req channel takes one stored byte per request, header first, with
// last_byte set on the final byte of the stream. The rsp channel returns the
// decoded bytes and, after the final byte, one status result; last_result
// marks the final result caused by each request.
// A header byte, control byte or first reference byte gives no result. A
// literal or an uncompressed body byte gives one result, valid in the cycle
// after the byte is taken. A reference of length L is expanded in steps:
// the step that takes its second byte, then a read of the history memory
// and, once the output register is free, a write back for each copied byte.
// When data results precede it, the status result comes from its own state.
// Results pass through one output register; a new request is taken only
// while that register is free or being emptied, so a stalled receiver
// holds the decoder in place without losing anything.
// Reset, and the end of every stream, return the decoding state to its start value;
// the history ring is restored at once through its fill count, with no
// clearing pass.
// ---------------------------------------------------------------------------
`include "compressed_rtf_lz_decoder_macros.svh"

module compressed_rtf_lz_decoder (
   input logic          clock,
   input logic          reset,
   crtf_req_if.sink     req,
   crtf_rsp_if.source   rsp
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_HEADER_RAW = 3'd1;
   localparam logic [2:0] PH_RAW = 3'd2;
   localparam logic [2:0] PH_CTRL = 3'd3;
   localparam logic [2:0] PH_TOKEN = 3'd4;
   localparam logic [2:0] PH_REF2 = 3'd5;
   localparam logic [2:0] PH_TAIL = 3'd6;
   localparam logic [2:0] PH_IDLE = 3'd7;

   localparam logic [1:0] SQ_IN = 2'd0;
   localparam logic [1:0] SQ_RD = 2'd1;
   localparam logic [1:0] SQ_WR = 2'd2;
   localparam logic [1:0] SQ_STAT = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_TYPE = 3'd2;
   localparam logic [2:0] ST_OVERRUN = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_CRC = 3'd5;

   localparam int unsigned Aw = crtf_pkg::RingAw;

   logic [1:0]    seq_ff, seq_in;
   logic [2:0]    phase_ff, phase_in;
   logic [3:0]    hcnt_ff, hcnt_in;
   logic [31:0]   hshift_ff, hshift_in;
   logic [31:0]   remain_ff, remain_in;
   logic [31:0]   exp_crc_ff, exp_crc_in;
   logic [31:0]   crc_ff, crc_in;
   logic [7:0]    flags_ff, flags_in;
   logic [2:0]    tok_ff, tok_in;
   logic [7:0]    ref1_ff, ref1_in;
   logic [2:0]    err_ff, err_in;
   logic          last_ff, last_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [Aw-1:0] rd_ff, rd_in;

   logic          rsp_v_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_dv_ff;
   logic          rsp_sv_ff;
   logic [2:0]    rsp_st_ff;
   logic          rsp_last_ff;

   logic          out_free;
   logic          accept;
   logic          emit;
   logic [7:0]    emit_byte;
   logic          emit_dv;
   logic          emit_sv;
   logic [2:0]    emit_st;
   logic          emit_last;
   logic          stream_clear;
   logic          ring_wr;
   logic [7:0]    ring_wdata;
   logic          ring_rd;
   logic [7:0]    ring_rdata;
   logic [Aw-1:0] ring_wp;

   logic [7:0]    b;
   logic [3:0]    idx;
   logic [31:0]   shift_n;
   logic [31:0]   crc_b;
   logic [15:0]   ref_word;
   logic [4:0]    ref_len;
   logic [2:0]    tok_n;

   function automatic logic [2:0] status_of(input logic [2:0] ph, input logic [31:0] crc,
                                            input logic [31:0] expc, input logic [2:0] err);
      logic [2:0] st;
      case (ph)
         PH_HEADER, PH_HEADER_RAW: st = ST_SHORT;
         PH_RAW: st = ST_OK;
         PH_TAIL: st = (crc == expc) ? ST_OK : ST_CRC;
         PH_IDLE: st = err;
         default: st = ST_OVERRUN;
      endcase
      return st;
   endfunction

   crtf_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (stream_clear),
      .wr_en   (ring_wr),
      .wr_data (ring_wdata),
      .rd_en   (ring_rd),
      .rd_addr (rd_ff),
      .rd_data (ring_rdata),
      .wr_pos  (ring_wp)
   );

   assign out_free = !rsp_v_ff || rsp.ready;
   assign req.ready = (seq_ff == SQ_IN) && out_free;
   assign accept = req.valid && req.ready;

   assign b = req.stream_byte;
   assign idx = hcnt_ff;
   assign shift_n = {b, hshift_ff[31:8]};
   assign crc_b = crtf_pkg::crc_byte(crc_ff, b);
   assign ref_word = {ref1_ff, b};
   assign ref_len = {1'b0, ref_word[3:0]} + 5'd2;
   assign tok_n = tok_ff + 1'b1;

   always_comb begin
      seq_in = seq_ff;
      phase_in = phase_ff;
      hcnt_in = hcnt_ff;
      hshift_in = hshift_ff;
      remain_in = remain_ff;
      exp_crc_in = exp_crc_ff;
      crc_in = crc_ff;
      flags_in = flags_ff;
      tok_in = tok_ff;
      ref1_in = ref1_ff;
      err_in = err_ff;
      last_in = last_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      emit = 1'b0;
      emit_byte = 8'h00;
      emit_dv = 1'b0;
      emit_sv = 1'b0;
      emit_st = ST_OK;
      emit_last = 1'b0;
      stream_clear = 1'b0;
      ring_wr = 1'b0;
      ring_wdata = b;
      ring_rd = 1'b0;

      case (seq_ff)
         SQ_IN: begin
            if (accept) begin
               case (phase_ff)
                  PH_HEADER, PH_HEADER_RAW: begin
                     hshift_in = shift_n;
                     if (idx == 4'd7) begin
                        remain_in = shift_n;
                     end
                     if (idx == 4'd11) begin
                        if (shift_n == crtf_pkg::TypeUncompressed) begin
                           phase_in = PH_HEADER_RAW;
                        end else if (shift_n != crtf_pkg::TypeCompressed) begin
                           err_in = ST_TYPE;
                        end
                     end
                     if (idx == 4'(crtf_pkg::HeaderBytes - 1)) begin
                        exp_crc_in = shift_n;
                        if (phase_ff == PH_HEADER_RAW) begin
                           phase_in = PH_RAW;
                        end else begin
                           phase_in = (err_ff != ST_OK) ? PH_IDLE : PH_CTRL;
                        end
                     end
                     hcnt_in = idx + 1'b1;
                  end
                  PH_RAW: begin
                     emit = 1'b1;
                     emit_byte = b;
                     emit_dv = 1'b1;
                  end
                  PH_CTRL: begin
                     crc_in = crc_b;
                     flags_in = b;
                     tok_in = '0;
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (!flags_ff[tok_ff]) begin
                        if (remain_ff == '0) begin
                           err_in = ST_OVERFLOW;
                           phase_in = PH_IDLE;
                        end else begin
                           crc_in = crc_b;
                           remain_in = remain_ff - 1'b1;
                           ring_wr = 1'b1;
                           emit = 1'b1;
                           emit_byte = b;
                           emit_dv = 1'b1;
                           tok_in = tok_n;
                           phase_in = (tok_n == '0) ? PH_CTRL : PH_TOKEN;
                        end
                     end else begin
                        crc_in = crc_b;
                        ref1_in = b;
                        phase_in = PH_REF2;
                     end
                  end
                  PH_REF2: begin
                     crc_in = crc_b;
                     if (ref_word[15:4] == ring_wp) begin
                        phase_in = PH_TAIL;
                     end else if ({27'h0, ref_len} > remain_ff) begin
                        err_in = ST_OVERFLOW;
                        phase_in = PH_IDLE;
                     end else begin
                        remain_in = remain_ff - {27'h0, ref_len};
                        rd_in = ref_word[15:4];
                        cnt_in = ref_len;
                        last_in = req.last_byte;
                        seq_in = SQ_RD;
                        tok_in = tok_n;
                        phase_in = (tok_n == '0) ? PH_CTRL : PH_TOKEN;
                     end
                  end
                  PH_TAIL: begin
                     crc_in = crc_b;
                  end
                  default: begin
                  end
               endcase

               if (req.last_byte && seq_in == SQ_IN) begin
                  if (emit) begin
                     seq_in = SQ_STAT;
                  end else begin
                     emit = 1'b1;
                     emit_sv = 1'b1;
                     emit_st = status_of(phase_in, crc_in, exp_crc_in, err_in);
                     emit_last = 1'b1;
                     stream_clear = 1'b1;
                  end
               end else if (emit) begin
                  emit_last = 1'b1;
               end
            end
         end
         SQ_RD: begin
            ring_rd = 1'b1;
            seq_in = SQ_WR;
         end
         SQ_WR: begin
            if (out_free) begin
               emit = 1'b1;
               emit_byte = ring_rdata;
               emit_dv = 1'b1;
               emit_last = (cnt_ff == 5'd1) && !last_ff;
               ring_wr = 1'b1;
               ring_wdata = ring_rdata;
               rd_in = rd_ff + 1'b1;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == 5'd1) begin
                  seq_in = last_ff ? SQ_STAT : SQ_IN;
               end else begin
                  seq_in = SQ_RD;
               end
            end
         end
         SQ_STAT: begin
            if (out_free) begin
               emit = 1'b1;
               emit_sv = 1'b1;
               emit_st = status_of(phase_ff, crc_ff, exp_crc_ff, err_ff);
               emit_last = 1'b1;
               stream_clear = 1'b1;
               seq_in = SQ_IN;
            end
         end
         default: begin
            seq_in = SQ_IN;
         end
      endcase

      if (stream_clear) begin
         phase_in = PH_HEADER;
         hcnt_in = '0;
         hshift_in = '0;
         remain_in = '0;
         exp_crc_in = '0;
         crc_in = '0;
         flags_in = '0;
         tok_in = '0;
         ref1_in = '0;
         err_in = ST_OK;
         last_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SQ_IN;
         phase_ff <= PH_HEADER;
         hcnt_ff <= '0;
         hshift_ff <= '0;
         remain_ff <= '0;
         exp_crc_ff <= '0;
         crc_ff <= '0;
         flags_ff <= '0;
         tok_ff <= '0;
         ref1_ff <= '0;
         err_ff <= ST_OK;
         last_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         phase_ff <= phase_in;
         hcnt_ff <= hcnt_in;
         hshift_ff <= hshift_in;
         remain_ff <= remain_in;
         exp_crc_ff <= exp_crc_in;
         crc_ff <= crc_in;
         flags_ff <= flags_in;
         tok_ff <= tok_in;
         ref1_ff <= ref1_in;
         err_ff <= err_in;
         last_ff <= last_in;
         cnt_ff <= cnt_in;
         if (emit) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_dv_ff <= emit_dv;
         rsp_sv_ff <= emit_sv;
         rsp_st_ff <= emit_st;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.out_valid = rsp_dv_ff;
   assign rsp.status_valid = rsp_sv_ff;
   assign rsp.status = rsp_st_ff;
   assign rsp.last_result = rsp_last_ff;

   `CRTF_ASSERT_NEXT(a_read_then_write, seq_ff == SQ_RD, seq_ff == SQ_WR, "copy read not followed by write")
   `CRTF_ASSERT_NOW(a_copy_count, seq_ff == SQ_RD || seq_ff == SQ_WR, cnt_ff != 5'd0, "copy with zero count")
   `CRTF_ASSERT_NOW(a_status_last, rsp_v_ff && rsp_sv_ff, rsp_last_ff && !rsp_dv_ff, "status result not final")

endmodule

// File: tb/compressed_rtf_lz_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compressed RTF decoder testbench
// Feeds directed and random compressed, uncompressed, broken and noise
// streams through the request channel. A software decoder predicts every
// result, and each result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module compressed_rtf_lz_decoder_test;

   typedef enum logic [2:0] {
      StOk = 3'd0, StShortHeader = 3'd1, StBadType = 3'd2,
      StOverrun = 3'd3, StOverflow = 3'd4, StCrcMismatch = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PhHeader, PhHeaderRaw, PhRaw, PhCtrl, PhToken, PhRef2, PhTail, PhIdle
   } dec_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       status_valid;
      logic [2:0] status;
      logic       last_result;
   } decoded_type;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
      logic       typed;
      logic [2:0] status;
   } stim_row_type;

   localparam int WatchdogLimit = 3000;
   localparam int ItemTarget = 150;

   logic clock;
   logic reset;
   crtf_req_if req ();
   crtf_rsp_if rsp ();

   compressed_rtf_lz_decoder uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   logic [7:0]    history [crtf_pkg::RingDepth];
   logic [11:0]   wr_pos;
   dec_phase_type dphase;
   logic [3:0]    hdr_count;
   logic [31:0]   hdr_shift;
   logic [32:0]   raw_left;
   logic [31:0]   hdr_crc;
   logic [31:0]   body_crc;
   logic [7:0]    flags;
   logic [2:0]    token_idx;
   logic [7:0]    ref_hi;
   logic [2:0]    err_code;
   logic          row_typed;
   logic [2:0]    row_status;

   decoded_type  decoded_q[$];
   stim_row_type stream_q[$];
   int errors = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
      c = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ crtf_pkg::CrcPoly) : (c >> 1);
      return c;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic decoder_clear();
      for (int i = 0; i < crtf_pkg::RingDepth; i++)
         history[12'(i)] = (i < crtf_pkg::PrefixLen) ?
            crtf_pkg::RtfPrefix[(crtf_pkg::PrefixLen - 1 - i) * 8 +: 8] : 8'h00;
      wr_pos = 12'(crtf_pkg::PrefixLen);
      dphase = PhHeader;
      hdr_count = 0;
      hdr_shift = 0;
      raw_left = 0;
      hdr_crc = 0;
      body_crc = 0;
      flags = 0;
      token_idx = 0;
      ref_hi = 0;
      err_code = 0;
   endtask

   task automatic emit(logic [7:0] b, logic ov, logic sv, logic [2:0] st);
      decoded_type r;
      r = '{out_byte: b, out_valid: ov, status_valid: sv, status: st, last_result: 1'b0};
      decoded_q.push_back(r);
   endtask

   task automatic advance_token();
      token_idx = token_idx + 3'd1;
      dphase = (token_idx == 0) ? PhCtrl : PhToken;
   endtask

   task automatic decode_byte(logic [7:0] b, logic last);
      int n;
      logic [15:0] rv;
      logic [11:0] rd;
      int len;
      logic [2:0] st;
      n = 0;
      case (dphase)
         PhHeader, PhHeaderRaw: begin
            hdr_shift = {b, hdr_shift[31:8]};
            if (hdr_count == 7) raw_left = {1'b0, hdr_shift};
            if (hdr_count == 11) begin
               if (hdr_shift == crtf_pkg::TypeUncompressed) dphase = PhHeaderRaw;
               else if (hdr_shift != crtf_pkg::TypeCompressed) err_code = StBadType;
            end
            if (hdr_count == 15) begin
               hdr_crc = hdr_shift;
               if (dphase == PhHeaderRaw) dphase = PhRaw;
               else dphase = (err_code != 0) ? PhIdle : PhCtrl;
            end
            hdr_count = hdr_count + 4'd1;
         end
         PhRaw: begin
            emit(b, 1'b1, 1'b0, StOk);
            n++;
         end
         PhCtrl: begin
            body_crc = crc32_step(body_crc, b);
            flags = b;
            token_idx = 0;
            dphase = PhToken;
         end
         PhToken: begin
            if (!flags[token_idx]) begin
               if (raw_left == 0) begin
                  err_code = StOverflow;
                  dphase = PhIdle;
               end else begin
                  body_crc = crc32_step(body_crc, b);
                  raw_left--;
                  history[wr_pos] = b;
                  wr_pos++;
                  emit(b, 1'b1, 1'b0, StOk);
                  n++;
                  advance_token();
               end
            end else begin
               body_crc = crc32_step(body_crc, b);
               ref_hi = b;
               dphase = PhRef2;
            end
         end
         PhRef2: begin
            rv = {ref_hi, b};
            rd = rv[15:4];
            len = int'(rv[3:0]) + 2;
            body_crc = crc32_step(body_crc, b);
            if (rd == wr_pos) dphase = PhTail;
            else if (33'(len) > raw_left) begin
               err_code = StOverflow;
               dphase = PhIdle;
            end else begin
               raw_left -= 33'(len);
               for (int i = 0; i < len; i++) begin
                  history[wr_pos] = history[rd];
                  emit(history[rd], 1'b1, 1'b0, StOk);
                  n++;
                  rd++;
                  wr_pos++;
               end
               advance_token();
            end
         end
         PhTail: body_crc = crc32_step(body_crc, b);
         default: ;
      endcase
      if (last) begin
         case (dphase)
            PhHeader, PhHeaderRaw: st = StShortHeader;
            PhRaw: st = StOk;
            PhTail: st = (body_crc == hdr_crc) ? StOk : StCrcMismatch;
            PhIdle: st = err_code;
            default: st = StOverrun;
         endcase
         emit(8'h00, 1'b0, 1'b1, st);
         n++;
         decoder_clear();
      end
      if (n > 0) decoded_q[$].last_result = 1'b1;
   endtask

   task automatic push_byte(logic [7:0] b, logic last);
      stream_q.push_back('{b: b, last: last, typed: 1'b0, status: StOk});
   endtask

   task automatic push_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) push_byte(w[i*8 +: 8], 1'b0);
   endtask

   // Kinds: 0 good, 1 CRC mismatch, 2 overflow, 3 overrun, 4 uncompressed, 5 noise.
   task automatic build_stream(int kind);
      logic [7:0] body[$];
      logic [7:0] fl;
      logic [11:0] wp;
      logic [11:0] off;
      logic [31:0] crc;
      logic [31:0] ty;
      int total;
      int len;
      int cut;
      wp = 12'(crtf_pkg::PrefixLen);
      total = 0;
      crc = 0;
      if (kind == 5) begin
         len = $urandom_range(1, 24);
         if ($urandom_range(0, 1)) begin
            push_word($urandom);
            push_word($urandom_range(0, 40));
            ty = $urandom_range(0, 3) == 0 ? $urandom :
                 crtf_pkg::TypeCompressed ^ (1 << $urandom_range(0, 31));
            push_word(ty);
            push_word($urandom);
         end
         for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
         return;
      end
      if (kind == 4) begin
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) body.push_back(8'($urandom));
         ty = crtf_pkg::TypeUncompressed;
      end else begin
         ty = crtf_pkg::TypeCompressed;
         for (int g = $urandom_range(1, 3); g > 0; g--) begin
            fl = 8'($urandom);
            body.push_back(fl);
            for (int t = 0; t < 8; t++) begin
               if (fl[t]) begin
                  len = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 4);
                  off = $urandom_range(0, 1) ? wp - 12'($urandom_range(1, 300)) : 12'($urandom);
                  if (off == wp) off++;
                  body.push_back(off[11:4]);
                  body.push_back({off[3:0], 4'(len)});
                  wp += 12'(len + 2);
                  total += len + 2;
               end else begin
                  body.push_back(8'($urandom));
                  wp++;
                  total++;
               end
            end
         end
         body.push_back({7'($urandom), 1'b1});
         body.push_back(wp[11:4]);
         body.push_back({wp[3:0], 4'($urandom)});
         for (int i = $urandom_range(0, 2); i > 0; i--) body.push_back(8'($urandom));
         if (kind == 3) begin
            cut = $urandom_range(1, body.size() - 3);
            while (body.size() > cut) void'(body.pop_back());
         end
      end
      foreach (body[i]) crc = crc32_step(crc, body[i]);
      push_word($urandom);
      if (kind == 2) push_word(total > 0 ? $urandom_range(0, total - 1) : 0);
      else push_word(total + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0));
      push_word(ty);
      push_word(kind == 1 ? crc ^ (1 << $urandom_range(0, 31)) : crc);
      foreach (body[i]) push_byte(body[i], i == body.size() - 1);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.stream_byte = 8'h00;
      req.last_byte = 1'b0;
      row_typed = 1'b0;
      row_status = StOk;
      rsp.ready = 1'b0;
      decoder_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   int ready_pct = 100;
   int stall_span = 0;
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
         endcase
      end
      stall_span--;
      rsp.ready <= !reset && ($urandom_range(0, 99) < ready_pct);
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         decode_byte(req.stream_byte, req.last_byte);
         if (row_typed && decoded_q[$].status !== row_status)
            report("predicted status", 32'(decoded_q[$].status), 32'(row_status));
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (decoded_q.size() == 0) begin
            report("unexpected result", 32'({rsp.out_byte, rsp.status}), 32'h0);
         end else begin
            decoded_type w;
            w = decoded_q.pop_front();
            if (rsp.out_byte !== w.out_byte)
               report("out_byte", 32'(rsp.out_byte), 32'(w.out_byte));
            if (rsp.out_valid !== w.out_valid)
               report("out_valid", 32'(rsp.out_valid), 32'(w.out_valid));
            if (rsp.status_valid !== w.status_valid)
               report("status_valid", 32'(rsp.status_valid), 32'(w.status_valid));
            if (rsp.status !== w.status) report("status", 32'(rsp.status), 32'(w.status));
            if (rsp.last_result !== w.last_result)
               report("last_result", 32'(rsp.last_result), 32'(w.last_result));
         end
      end
      if (!reset && ((req.valid && req.ready) || (rsp.valid && rsp.ready))) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("compressed_rtf_lz_decoder verification failed");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int burst;
      // Short header with extreme bytes, then a complete header of an unknown type.
      stream_q.push_back('{b: 8'h00, last: 1'b0, typed: 1'b0, status: StOk});
      stream_q.push_back('{b: 8'hff, last: 1'b1, typed: 1'b1, status: StShortHeader});
      push_word(32'hffffffff);
      push_word(32'h00000000);
      push_word(32'h12345678);
      push_word(32'hffffffff);
      stream_q.push_back('{b: 8'h5a, last: 1'b1, typed: 1'b1, status: StBadType});
      burst = 0;
      @(negedge reset);
      @(posedge clock);
      for (int phase_no = 0; phase_no < 2; phase_no++) begin
         if (phase_no == 1) begin
            while (items_sent < ItemTarget) begin
               build_stream($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 5));
               items_sent += 0;
               break;
            end
         end
         while (stream_q.size() > 0) begin
            row = stream_q.pop_front();
            req.valid <= 1'b1;
            req.stream_byte <= row.b;
            req.last_byte <= row.last;
            row_typed <= row.typed;
            row_status <= row.status;
            @(posedge clock);
            while (!req.ready) @(posedge clock);
            items_sent++;
            if (phase_no == 1 && stream_q.size() == 0 && items_sent < ItemTarget)
               build_stream($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 5));
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               if ($urandom_range(0, 2) != 0) begin
                  req.valid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
            burst--;
         end
      end
      req.valid <= 1'b0;
      while (decoded_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("compressed_rtf_lz_decoder verification clean");
      else $display("compressed_rtf_lz_decoder verification failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/crtf_pkg.sv
design/crtf_req_if.sv
design/crtf_rsp_if.sv
design/crtf_ring.sv
design/compressed_rtf_lz_decoder.sv
tb/compressed_rtf_lz_decoder_test.sv
